// ===== sv/sbc_pkg.sv =====
// Shared constants, types and codes for the splitter bucket classifier.
package sbc_pkg;

  localparam int MAX_SPLITTERS = 1024;
  localparam int KEY_BITS      = 64;

  localparam int ADDR_W   = $clog2(MAX_SPLITTERS);
  localparam int CNT_W    = $clog2(MAX_SPLITTERS + 1);
  localparam int BUCKET_W = CNT_W + 1;

  localparam int IDX_W    = 10;
  localparam int VALUE_W  = 64;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  typedef enum logic {
    REQ_WRITE    = 1'b0,
    REQ_CLASSIFY = 1'b1
  } req_type_t;

  typedef enum logic {
    REG_SPLITTER_COUNT  = 1'b0,
    REG_EQUAL_EXIT_MODE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0] splitter_count;
    logic             equal_exit_mode;
  } cfg_t;

  typedef struct packed {
    logic                en;
    logic [ADDR_W-1:0]   addr;
    logic [KEY_BITS-1:0] data;
  } ram_wr_t;

endpackage

// ===== sv/sbc_if.sv =====
// Request and response channel interfaces.
interface sbc_req_if import sbc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [IDX_W-1:0]   table_index;
  logic [VALUE_W-1:0] splitter_value;
  logic [VALUE_W-1:0] search_key;

  modport source (output valid, req_type, table_index, splitter_value, search_key,
                  input ready);
  modport sink   (input valid, req_type, table_index, splitter_value, search_key,
                  output ready);
endinterface

interface sbc_rsp_if import sbc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BUCKET_W-1:0] bucket_index;
  logic                equal_match;

  modport source (output valid, bucket_index, equal_match, input ready);
  modport sink   (input valid, bucket_index, equal_match, output ready);
endinterface

// ===== sv/sbc_cfg_regs.sv =====
// Configuration register file behind the APB-style port.
module sbc_cfg_regs import sbc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [CNT_W-1:0] splitter_count;
  logic             equal_exit_mode;
  reg_idx_t         reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      splitter_count  <= '0;
      equal_exit_mode <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SPLITTER_COUNT:  splitter_count  <= pwdata[CNT_W-1:0];
        REG_EQUAL_EXIT_MODE: equal_exit_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SPLITTER_COUNT:  prdata = PDATA_W'(splitter_count);
      REG_EQUAL_EXIT_MODE: prdata = PDATA_W'(equal_exit_mode);
      default:             prdata = '0;
    endcase
  end

  assign cfg.splitter_count  = splitter_count;
  assign cfg.equal_exit_mode = equal_exit_mode;

endmodule

// ===== sv/sbc_table_ram.sv =====
// Splitter table memory: one write port, one read port, registered read data.
module sbc_table_ram import sbc_pkg::*; (
  input  logic                clk,
  input  ram_wr_t             wr,
  input  logic [ADDR_W-1:0]   raddr,
  output logic [KEY_BITS-1:0] rdata
);

  logic [KEY_BITS-1:0] mem [MAX_SPLITTERS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/sbc_search_ctrl.sv =====
// Binary search sequencer over the splitter table, with output register.
module sbc_search_ctrl import sbc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  sbc_req_if.sink             req,
  sbc_rsp_if.source           rsp,
  output ram_wr_t             wr,
  output logic [ADDR_W-1:0]   raddr,
  input  logic [KEY_BITS-1:0] rdata
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PROBE = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t              state, state_next;
  logic [CNT_W-1:0]    lo, lo_next;
  logic [CNT_W-1:0]    hi, hi_next;
  logic [CNT_W-1:0]    mid, mid_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [KEY_BITS-1:0] key, key_next;
  logic                mode, mode_next;
  logic [CNT_W-1:0]    res_lo, res_lo_next;
  logic                res_match, res_match_next;
  logic                out_valid;
  logic [BUCKET_W-1:0] out_bucket;
  logic                out_match;
  logic                load_out;
  logic [CNT_W-1:0]    cnt_sat;
  logic                key_eq;
  logic                key_le;

  assign cnt_sat = (cfg.splitter_count > CNT_W'(MAX_SPLITTERS)) ?
                   CNT_W'(MAX_SPLITTERS) : cfg.splitter_count;
  assign key_eq  = (key == rdata);
  assign key_le  = (key <= rdata);

  assign req.ready        = (state == ST_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.bucket_index = out_bucket;
  assign rsp.equal_match  = out_match;

  always_comb begin
    logic [CNT_W-1:0] step_lo;
    logic [CNT_W-1:0] step_hi;
    logic [CNT_W:0]   sum;

    state_next     = state;
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid;
    cnt_next       = cnt;
    key_next       = key;
    mode_next      = mode;
    res_lo_next    = res_lo;
    res_match_next = res_match;
    load_out       = 1'b0;
    raddr          = mid[ADDR_W-1:0];
    wr.en          = 1'b0;
    wr.addr        = req.table_index[ADDR_W-1:0];
    wr.data        = req.splitter_value[KEY_BITS-1:0];
    step_lo        = lo;
    step_hi        = hi;
    sum            = '0;

    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          if (req.req_type == REQ_WRITE) begin
            wr.en = 1'b1;
          end else begin
            key_next  = req.search_key[KEY_BITS-1:0];
            mode_next = cfg.equal_exit_mode;
            cnt_next  = cnt_sat;
            lo_next   = '0;
            hi_next   = cnt_sat;
            mid_next  = cnt_sat >> 1;
            raddr     = mid_next[ADDR_W-1:0];
            if (cnt_sat == '0) begin
              res_lo_next    = '0;
              res_match_next = 1'b0;
              state_next     = ST_DONE;
            end else begin
              state_next = ST_PROBE;
            end
          end
        end
      end
      ST_PROBE: begin
        if (mode && key_eq) begin
          // early exit on the probed entry
          res_lo_next    = mid;
          res_match_next = 1'b1;
          state_next     = ST_DONE;
        end else begin
          if (key_le) begin
            step_lo = lo;
            step_hi = mid;
          end else begin
            step_lo = mid + CNT_W'(1);
            step_hi = hi;
          end
          lo_next  = step_lo;
          hi_next  = step_hi;
          sum      = {1'b0, step_lo} + {1'b0, step_hi};
          mid_next = sum[CNT_W:1];
          if (step_lo < step_hi) begin
            raddr = mid_next[ADDR_W-1:0];
          end else if (!mode && (step_lo < cnt)) begin
            raddr      = step_lo[ADDR_W-1:0];
            state_next = ST_CHECK;
          end else begin
            res_lo_next    = step_lo;
            res_match_next = 1'b0;
            state_next     = ST_DONE;
          end
        end
      end
      ST_CHECK: begin
        res_lo_next    = lo;
        res_match_next = key_eq;
        state_next     = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo        <= lo_next;
    hi        <= hi_next;
    mid       <= mid_next;
    cnt       <= cnt_next;
    key       <= key_next;
    mode      <= mode_next;
    res_lo    <= res_lo_next;
    res_match <= res_match_next;
    if (load_out) begin
      out_bucket <= {res_lo, res_match};
      out_match  <= res_match;
    end
  end

endmodule

// ===== sv/splitter_bucket_classifier.sv =====
// Top level of the splitter bucket classifier.
//
//  channel | dir | handshake                       | payload
//  --------+-----+---------------------------------+---------------------------------------
//  req     | in  | req.valid / req.ready           | req_type, table_index, splitter_value,
//          |     |                                 | search_key
//  rsp     | out | rsp.valid / rsp.ready           | bucket_index, equal_match
//  apb     | in  | psel, penable, pwrite, pready   | paddr, pwdata, prdata
//
// A write request is stored at its accept edge. A classify request runs P
// search levels (floor(log2(count)) or one more for a nonzero count, so at most
// 11 at 1024 splitters; fewer when mode 1 hits an equal splitter; 0 for an
// empty table) after its accept step, then, in mode 0 when the lower bound
// lies inside the table, a final equality read, then a finish step. The single
// read port of the splitter memory sets the pace: one table read per search
// level.
// Reset: clears the state machine, the output valid flag and both registers;
// the splitter table is not cleared and must be written before it is searched.
// Stalls: a finished result holds in the output register while rsp.ready is
// low; the next request is accepted meanwhile, and a second classify result
// waits in its finish step until the register drains.
module splitter_bucket_classifier import sbc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  sbc_req_if.sink            req,
  sbc_rsp_if.source          rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t                cfg;
  ram_wr_t             wr;
  logic [ADDR_W-1:0]   raddr;
  logic [KEY_BITS-1:0] rdata;

  // Register file: splitter count and equal exit mode.
  sbc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Splitter table. Writes happen only while the sequencer is idle and read data
  // is used only while a search runs, so a write never meets a read whose data
  // is used in the same cycle and no forwarding is needed.
  sbc_table_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Search sequencer: issue one probe address per cycle, compare the
  // returned splitter against the key, narrow the range, drive the result.
  sbc_search_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .req   (req),
    .rsp   (rsp),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

// ===== sv/sbc_checker.sv =====
// Port-level checker for the splitter bucket classifier, with its bind.
module sbc_checker import sbc_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                req_type,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [BUCKET_W-1:0] bucket_index,
  input logic                equal_match
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(bucket_index) && $stable(equal_match))
    else $error("response payload changed while stalled");

  a_match_odd: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (equal_match == bucket_index[0]))
    else $error("equal flag disagrees with bucket parity");

  a_classify_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_type == REQ_CLASSIFY) |=> !req_ready)
    else $error("request taken during a running search");

  a_bucket_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (bucket_index <= BUCKET_W'(2 * MAX_SPLITTERS)))
    else $error("bucket beyond table range");

endmodule

bind splitter_bucket_classifier sbc_checker u_sbc_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_type     (req.req_type),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .bucket_index (rsp.bucket_index),
  .equal_match  (rsp.equal_match)
);
